// File: design/q8bd_pkg.sv
// ---------------------------------------------------------------------------
// q8bd_pkg: shared constant and function of the block dequantizer
// Half to single widening; BF16 product rounding is in the dequantizer module.
// ---------------------------------------------------------------------------
package q8bd_pkg;

  localparam int unsigned ValuesPerBlockDflt = 32;

  // Widen an FP16 pattern to FP32 exactly (subnormals normalized).
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  expo;
    logic [10:0] frac;
    logic [7:0]  e;
    logic [3:0]  steps;
    expo  = h[14:10];
    frac  = {1'b0, h[9:0]};
    steps = 4'd0;
    e     = 8'd0;
    if (expo == 5'd0) begin
      if (h[9:0] == 10'd0) begin
        return {h[15], 31'd0};
      end
      for (int i = 9; i >= 0; i--) begin
        if (frac[i] && steps == 4'd0) steps = 4'(10 - i);
      end
      frac = frac << steps;
      e    = 8'd113 - {4'd0, steps};
      return {h[15], e, frac[9:0], 13'd0};
    end
    if (expo == 5'h1f) begin
      return {h[15], 8'hff, h[9:0], 13'd0};
    end
    e = {3'd0, expo} + 8'd112;
    return {h[15], e, h[9:0], 13'd0};
  endfunction

endpackage

// File: design/q8_block_dequantize_bf16.sv
// ---------------------------------------------------------------------------
// q8_block_dequantize_bf16: 8-bit block-quantized bytes to BF16 values
// Byte stream of scale-prefixed blocks in, one BF16 value per data byte out.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while the output is not stalled. Each block is
// two scale bytes (FP16, low byte first) followed by VALUES_PER_BLOCK signed
// int8 values; scale bytes give no result, each value byte gives one BF16
// result (scale * q, round to nearest even). The accepted byte and the
// widened scale sit in the stage 1 register; product and rounding are
// combinational from there into the output register. The pipeline, and with
// it in_ready_o, holds only while the output register is full and not taken.
// last_in_block_o marks the final value of a block, last_in_job_o the final
// value of block number blocks_in_job (never when that register is zero).
module q8_block_dequantize_bf16
  import q8bd_pkg::*;
#(
  parameter int unsigned VALUES_PER_BLOCK = ValuesPerBlockDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] value_bf16_o,
  output logic        last_in_block_o,
  output logic        last_in_job_o
);

  localparam int unsigned PosW = $clog2(VALUES_PER_BLOCK + 2);
  localparam logic [PosW-1:0] LastPos = PosW'(VALUES_PER_BLOCK + 1);

  logic [15:0]       blocks_in_job_q;
  logic [PosW-1:0]   pos_q;
  logic [7:0]        scale_lo_q;
  logic [15:0]       scale_q;
  logic [15:0]       done_q;

  // stage 1 register: value byte, widened scale, flags
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic [31:0]       s1_scale_q;
  logic              s1_lblk_q, s1_ljob_q;

  logic              out_valid_q;
  logic [15:0]       out_val_q;
  logic              out_lblk_q, out_ljob_q;

  logic              adv;
  logic              in_acc;
  logic              is_val;
  logic              lblk, ljob;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_val     = pos_q > PosW'(1);
  assign lblk       = (pos_q == LastPos);
  assign ljob       = lblk && (blocks_in_job_q != 16'd0) && (done_q + 16'd1 == blocks_in_job_q);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_job_q <= 16'd0;
    end else if (cfg_we_i) begin
      blocks_in_job_q <= cfg_wdata_i;
    end
  end

  // block position, scale capture and block count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      scale_lo_q <= 8'd0;
      scale_q    <= 16'd0;
      done_q     <= 16'd0;
    end else if (in_acc) begin
      if (pos_q == PosW'(0)) begin
        scale_lo_q <= data_byte_i;
        pos_q      <= PosW'(1);
      end else if (pos_q == PosW'(1)) begin
        scale_q <= {data_byte_i, scale_lo_q};
        pos_q   <= PosW'(2);
      end else if (lblk) begin
        pos_q  <= '0;
        done_q <= ljob ? 16'd0 : done_q + 16'd1;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc && is_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_byte_q  <= data_byte_i;
      s1_scale_q <= half_to_single(scale_q);
      s1_lblk_q  <= lblk;
      s1_ljob_q  <= ljob;
    end
  end

  // product: 24-bit mantissa times 7-bit magnitude (-128 as a shift), normalize, round to BF16
  logic        qneg, psign;
  logic [6:0]  qmag;
  logic [23:0] mant;
  logic [30:0] prod;
  logic [7:0]  e;
  logic [4:0]  lz;
  logic [30:0] norm;
  logic [31:0] pb;
  logic [31:0] rnd;
  logic [15:0] res_d;

  always_comb begin
    qneg  = s1_byte_q[7];
    psign = s1_scale_q[31] ^ qneg;
    qmag  = qneg ? 7'(8'd0 - s1_byte_q) : s1_byte_q[6:0];
    mant  = {1'b1, s1_scale_q[22:0]};
    prod  = {7'd0, mant} * {24'd0, (s1_byte_q == 8'h80) ? 7'd0 : qmag};
    if (s1_byte_q == 8'h80) prod = {mant, 7'd0};
    lz = 5'd0;
    for (int i = 23; i <= 30; i++) begin
      if (prod[i]) lz = 5'(i - 23);
    end
    norm = prod >> lz;
    e    = s1_scale_q[30:23] + {3'd0, lz};
    pb   = {psign, e, norm[22:0]};
    rnd  = pb + 32'h7fff + {31'd0, pb[16]};
    if (s1_scale_q[30:23] == 8'hff) begin
      if (s1_scale_q[22:0] != 23'd0) res_d = s1_scale_q[31:16] | 16'h0040;
      else if (s1_byte_q == 8'd0)    res_d = 16'h7fc0;
      else                           res_d = {psign, 15'h7f80};
    end else if (s1_byte_q == 8'd0 || s1_scale_q[30:0] == 31'd0) begin
      res_d = {psign, 15'd0};
    end else begin
      res_d = rnd[31:16];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_val_q  <= res_d;
      out_lblk_q <= s1_lblk_q;
      out_ljob_q <= s1_ljob_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_bf16_o    = out_val_q;
  assign last_in_block_o = out_lblk_q;
  assign last_in_job_o   = out_ljob_q;

  // checks
  a_job_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_ljob_q || out_lblk_q))
    else $error("job end without block end");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_val_q)))
    else $error("stalled result changed");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("position out of range");
  // any NaN result leaves as a quiet NaN
  a_nan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_val_q[14:7] == 8'hff && out_val_q[6:0] != 7'd0)
      |-> out_val_q[6])
    else $error("signaling NaN on output");

endmodule
